/* sv/dsti_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the decimal string to integer converter.
// No dependencies.
package dsti_pkg;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_U64  = 4'd0;
    localparam kind_t KIND_S64  = 4'd1;
    localparam kind_t KIND_U32  = 4'd2;
    localparam kind_t KIND_S32  = 4'd3;
    localparam kind_t KIND_U16  = 4'd4;
    localparam kind_t KIND_S16  = 4'd5;
    localparam kind_t KIND_U8   = 4'd6;
    localparam kind_t KIND_S8   = 4'd7;
    localparam kind_t KIND_BOOL = 4'd8;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_APOS  = 8'h27;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // floor((2^64 - 1) / 10): largest accumulator that can take another digit
    localparam logic [63:0] MAG_LIMIT_DIV10 = 64'd1844674407370955161;
    localparam logic [3:0]  LIMIT_LAST_DIGIT = 4'd5;

    // Per-string parse state
    typedef struct packed {
        logic [63:0] acc;
        logic        negative;
        logic        in_digits;
        logic        failed;
        logic        at_first;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        acc:       64'd0,
        negative:  1'b0,
        in_digits: 1'b0,
        failed:    1'b0,
        at_first:  1'b1
    };

    function automatic logic kind_is_signed(input kind_t k);
        return (k == KIND_S64) || (k == KIND_S32) || (k == KIND_S16) || (k == KIND_S8);
    endfunction

endpackage

/* sv/dsti_step.sv */
`timescale 1ns / 1ps
// Per-character state update: NUL clear, bool, prefix/sign handling, digit accumulate, failure.
// Depends on dsti_pkg.
module dsti_step (
    input  logic [7:0]            char_code,
    input  dsti_pkg::kind_t       kind,
    input  dsti_pkg::parse_state_t cur,
    output dsti_pkg::parse_state_t nxt
);
    import dsti_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic        mag_over;
    logic [63:0] acc_x10d;
    logic        is_skip;

    always_comb
    begin
        is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        digit    = 4'(char_code - CHAR_ZERO);
        mag_over = (cur.acc > MAG_LIMIT_DIV10) ||
                   ((cur.acc == MAG_LIMIT_DIV10) && (digit > LIMIT_LAST_DIGIT));
        // acc*10 + d as shift-add, wraps mod 2^64
        acc_x10d = (cur.acc << 3) + (cur.acc << 1) + {60'd0, digit};
        is_skip  = (char_code == CHAR_SPACE) || (char_code == CHAR_COMMA) ||
                   (char_code == CHAR_APOS);
    end

    always_comb
    begin
        nxt = cur;
        if (char_code == CHAR_NUL)
        begin
            nxt = PARSE_CLEAR;
        end
        else
        begin
            if (kind == KIND_BOOL)
            begin
                if (cur.at_first)
                    nxt.acc = {63'd0, (char_code != CHAR_ZERO)};
            end
            else if (!cur.failed)
            begin
                if (kind_is_signed(kind) && !cur.in_digits)
                begin
                    if (char_code == CHAR_MINUS)
                    begin
                        nxt.negative = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        nxt.in_digits = 1'b1;
                        nxt.failed    = mag_over;
                        nxt.acc       = acc_x10d;
                    end
                    else if (char_code != CHAR_SPACE)
                    begin
                        nxt.failed = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    nxt.failed = mag_over;
                    nxt.acc    = acc_x10d;
                end
                else if (!is_skip)
                begin
                    nxt.failed = 1'b1;
                end
            end
            nxt.at_first = 1'b0;
        end
    end

endmodule

/* sv/dsti_result.sv */
`timescale 1ns / 1ps
// End-of-string result: sign apply, range check and width cut per kind.
// Depends on dsti_pkg.
module dsti_result (
    input  dsti_pkg::kind_t        kind,
    input  dsti_pkg::parse_state_t cur,
    output logic [63:0]            value,
    output logic                   ok
);
    import dsti_pkg::*;

    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] mag;
    logic [63:0] signed_val;
    logic        range_bad;

    always_comb
    begin
        case (kind)
            KIND_U32, KIND_S32:
            begin
                mask = 64'h0000_0000_FFFF_FFFF;
                half = 64'h0000_0000_8000_0000;
            end
            KIND_U16, KIND_S16:
            begin
                mask = 64'h0000_0000_0000_FFFF;
                half = 64'h0000_0000_0000_8000;
            end
            KIND_U8, KIND_S8:
            begin
                mask = 64'h0000_0000_0000_00FF;
                half = 64'h0000_0000_0000_0080;
            end
            default:
            begin
                mask = 64'hFFFF_FFFF_FFFF_FFFF;
                half = 64'h8000_0000_0000_0000;
            end
        endcase
    end

    always_comb
    begin
        // failure before any digit: report the sign alone
        mag        = (cur.failed && !cur.in_digits) ? 64'd1 : cur.acc;
        signed_val = cur.negative ? (64'd0 - mag) : mag;
        range_bad  = cur.negative ? (mag > half) : (mag >= half);

        if (kind == KIND_BOOL)
        begin
            value = cur.at_first ? 64'd0 : {63'd0, cur.acc[0]};
            ok    = 1'b1;
        end
        else if (kind_is_signed(kind))
        begin
            value = signed_val & mask;
            ok    = !cur.failed && !range_bad;
        end
        else
        begin
            value = cur.acc & mask;
            ok    = !cur.failed && (cur.acc <= mask);
        end
    end

endmodule

/* sv/decimal_string_to_integer.sv */
`timescale 1ns / 1ps
// Decimal string to integer converter, top level: one character per transfer.
// A NUL is taken into the input stage, then loads the output register that
// raises out_valid. Throughput: one character per cycle; a held result stalls
// input only while a second NUL sits in the input stage.
// Reset (rst_n, async low) empties both registers, clears parse state and
// sets result_kind to u64. Depends on dsti_pkg, dsti_step, dsti_result.
module decimal_string_to_integer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: result_kind
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // character input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value,
    output logic        ok
);
    import dsti_pkg::*;

    kind_t        kind_reg;

    // input stage
    logic         stg_valid_reg;
    logic [7:0]   stg_char_reg;

    // parse state, carried across the characters of one string
    parse_state_t state_reg;
    parse_state_t state_next;

    // output register
    logic         out_valid_reg;
    logic [63:0]  value_reg;
    logic         ok_reg;

    logic         stg_is_term;
    logic         out_free;
    logic         stg_adv;
    logic [63:0]  res_value;
    logic         res_ok;

    // A staged NUL needs the output register; other characters only touch
    // parse state and always advance.
    assign stg_is_term = (stg_char_reg == CHAR_NUL);
    assign out_free    = !out_valid_reg || out_ready;
    assign stg_adv     = stg_valid_reg && (!stg_is_term || out_free);
    assign in_ready    = !stg_valid_reg || stg_adv;

    dsti_step u_step (
        .char_code (stg_char_reg),
        .kind      (kind_reg),
        .cur       (state_reg),
        .nxt       (state_next)
    );

    // result is formed from the state left by the characters before the NUL
    dsti_result u_result (
        .kind  (kind_reg),
        .cur   (state_reg),
        .value (res_value),
        .ok    (res_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_U64;
        else if (cfg_we)
            kind_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_ready)
            stg_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stg_char_reg <= char_code;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_CLEAR;
        else if (stg_adv)
            state_reg <= state_next;
    end

    // output register: loads on a NUL transfer out of the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stg_adv && stg_is_term)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv && stg_is_term)
        begin
            value_reg <= res_value;
            ok_reg    <= res_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign ok        = ok_reg;

endmodule
